>>> hdl/cpqb_pkg.sv
// Shared types, codes and reset values for the coin pulse qualifier batcher.
`timescale 1ns / 1ps

package cpqb_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [CmdW-1:0] {
    CMD_EDGE = 2'd0,
    CMD_POLL = 2'd1,
    CMD_ARM  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PULSE_MIN = 3'd0,
    REG_PULSE_MAX = 3'd1,
    REG_DEBOUNCE  = 3'd2,
    REG_ARM_GUARD = 3'd3,
    REG_WAIT      = 3'd4
  } reg_idx_t;

  localparam logic [CfgW-1:0] PulseMinRst = 16'd20;
  localparam logic [CfgW-1:0] PulseMaxRst = 16'd150;
  localparam logic [CfgW-1:0] DebounceRst = 16'd30;
  localparam logic [CfgW-1:0] ArmGuardRst = 16'd100;
  localparam logic [CfgW-1:0] WaitRst     = 16'd500;

  typedef struct packed {
    logic [CfgW-1:0] pulse_min_ms;
    logic [CfgW-1:0] pulse_max_ms;
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] arm_guard_ms;
    logic [CfgW-1:0] wait_ms;
  } cfg_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [TimeW-1:0] now_ms;
    logic             pin_low;
    logic             slot_active;
  } item_t;

  typedef struct packed {
    logic              batch_valid;
    logic [CountW-1:0] coin_total;
    logic              collecting;
  } result_t;

endpackage

>>> hdl/cpqb_core.sv
// Pulse qualification and batch state: one item evaluated per cycle while fire is high.
`timescale 1ns / 1ps

module cpqb_core import cpqb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    fire,
  output result_t res
);

  logic [TimeW-1:0]  pulse_start_r, pulse_start_nxt;
  logic              pulse_open_r, pulse_open_nxt;
  logic [TimeW-1:0]  last_counted_r, last_counted_nxt;
  logic [CountW-1:0] pulse_count_r, pulse_count_nxt;
  logic [TimeW-1:0]  armed_time_r, armed_time_nxt;
  logic              batch_open_r, batch_open_nxt;

  logic [TimeW-1:0] since_arm, since_last, width;
  logic             guarded, width_ok, spaced, quiet;

  assign since_arm  = item.now_ms - armed_time_r;
  assign since_last = item.now_ms - last_counted_r;
  assign width      = item.now_ms - pulse_start_r;
  assign guarded    = since_arm < {{(TimeW-CfgW){1'b0}}, cfg.arm_guard_ms};
  assign width_ok   = (width >= {{(TimeW-CfgW){1'b0}}, cfg.pulse_min_ms}) &&
                      (width <= {{(TimeW-CfgW){1'b0}}, cfg.pulse_max_ms});
  assign spaced     = since_last >= {{(TimeW-CfgW){1'b0}}, cfg.debounce_ms};
  assign quiet      = since_last >= {{(TimeW-CfgW){1'b0}}, cfg.wait_ms};

  always_comb begin
    pulse_start_nxt  = pulse_start_r;
    pulse_open_nxt   = pulse_open_r;
    last_counted_nxt = last_counted_r;
    pulse_count_nxt  = pulse_count_r;
    armed_time_nxt   = armed_time_r;
    batch_open_nxt   = batch_open_r;
    res.batch_valid  = 1'b0;
    res.coin_total   = '0;
    case (item.cmd)
      CMD_EDGE: begin
        if (item.slot_active && !guarded) begin
          if (item.pin_low) begin
            // restart the candidate pulse on every falling edge outside the guard with the slot active
            pulse_start_nxt = item.now_ms;
            pulse_open_nxt  = 1'b1;
          end else if (pulse_open_r) begin
            pulse_open_nxt = 1'b0;
            if (width_ok && spaced) begin
              if (pulse_count_r != CountMax) begin
                pulse_count_nxt = pulse_count_r + 1'b1;
              end
              last_counted_nxt = item.now_ms;
            end
          end
        end
      end
      CMD_POLL: begin
        if (pulse_count_r != '0) begin
          batch_open_nxt = 1'b1;
          if (quiet) begin
            res.batch_valid = 1'b1;
            res.coin_total  = pulse_count_r;
            pulse_count_nxt = '0;
            batch_open_nxt  = 1'b0;
          end
        end
      end
      CMD_ARM: begin
        armed_time_nxt = item.now_ms;
      end
      default: begin
      end
    endcase
    res.collecting = batch_open_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_start_r  <= '0;
      pulse_open_r   <= 1'b0;
      last_counted_r <= '0;
      pulse_count_r  <= '0;
      armed_time_r   <= '0;
      batch_open_r   <= 1'b0;
    end else if (fire) begin
      pulse_start_r  <= pulse_start_nxt;
      pulse_open_r   <= pulse_open_nxt;
      last_counted_r <= last_counted_nxt;
      pulse_count_r  <= pulse_count_nxt;
      armed_time_r   <= armed_time_nxt;
      batch_open_r   <= batch_open_nxt;
    end
  end

endmodule

>>> hdl/coin_pulse_qualifier_batcher_unit.sv
// Top level of the coin pulse qualifier batcher: ports, word registers, config.
`timescale 1ns / 1ps

// Usage
//   Input stream (in_*): one word per coin acceptor event. in_tuser carries the
//   command (pin edge, poll, relay armed), in_tdata the timestamp and levels.
//   Output stream (out_*): exactly one result word for every input word, in
//   order. out_tuser flags a finished batch, out_tdata holds its total and the
//   collecting flag.
//   Config port (cfg_*): five 16-bit registers, written one per cycle while
//   cfg_we is high; write only while the block is idle.
// Timing
//   A word is captured in the input register, evaluated against the pulse and
//   batch state, and lands in the output register. One word per cycle is
//   sustained while out_tready stays high; the single compare stage between
//   the two registers sets that rate.
// Reset and stall
//   rst_n (synchronous, active low) empties both word registers, clears the
//   pulse and batch state and loads the register defaults. When the receiver
//   stalls, the result holds in the output register, the next word waits in
//   the input register, and in_tready drops only once both are full.
module coin_pulse_qualifier_batcher_unit import cpqb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [39:0]        in_tdata,   // [31:0] now_ms, [32] pin_low, [33] slot_active
  input  logic [CmdW-1:0]    in_tuser,   // [1:0] cmd
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,  // [7:0] coin_total, [8] collecting
  output logic               out_tuser,  // [0] batch_valid
  // register writes
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  cfg_t    cfg_r;
  item_t   item_r;
  logic    in_valid_r;
  result_t res, res_r;
  logic    out_valid_r;
  logic    advance, fire;

  // advance the output register whenever it is empty or being drained
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // hold the config; drop writes to unused indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_min_ms <= PulseMinRst;
      cfg_r.pulse_max_ms <= PulseMaxRst;
      cfg_r.debounce_ms  <= DebounceRst;
      cfg_r.arm_guard_ms <= ArmGuardRst;
      cfg_r.wait_ms      <= WaitRst;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PULSE_MIN: cfg_r.pulse_min_ms <= cfg_data;
        REG_PULSE_MAX: cfg_r.pulse_max_ms <= cfg_data;
        REG_DEBOUNCE:  cfg_r.debounce_ms  <= cfg_data;
        REG_ARM_GUARD: cfg_r.arm_guard_ms <= cfg_data;
        REG_WAIT:      cfg_r.wait_ms      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.cmd         <= cmd_t'(in_tuser);
      item_r.now_ms      <= in_tdata[31:0];
      item_r.pin_low     <= in_tdata[32];
      item_r.slot_active <= in_tdata[33];
    end
  end

  cpqb_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .item  (item_r),
    .fire  (fire),
    .res   (res)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.batch_valid;
  assign out_tdata  = {7'd0, res_r.collecting, res_r.coin_total};

endmodule

>>> hdl/cpqb_checker.sv
// Port-level checks for the coin pulse qualifier batcher, bound to the top level.
`timescale 1ns / 1ps

module cpqb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // a reported batch never has a zero total
  a_batch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:0] != 8'd0)
    else $error("finished batch with zero total");

  // without a batch report the total reads zero
  a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'd0)
    else $error("total shown without batch report");

  // a reported batch closes collection
  a_batch_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[8])
    else $error("collecting still set after batch report");

endmodule

bind coin_pulse_qualifier_batcher_unit cpqb_checker u_cpqb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> dv/cpqb_batch_checker.sv
// Watches the coin pulse qualifier batcher streams, predicts every result and compares it.
`timescale 1ns / 1ps

module cpqb_batch_checker import cpqb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [39:0]        in_tdata,   // [31:0] now_ms, [32] pin_low, [33] slot_active
  input  logic [CmdW-1:0]    in_tuser,   // [1:0] cmd
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [15:0]        out_tdata,  // [7:0] coin_total, [8] collecting
  input  logic               out_tuser,  // [0] batch_valid
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  output int                 mismatches,
  output int                 results_due,
  output int                 results_seen,
  output int                 batches_seen
);

  cfg_t              regs;
  logic [TimeW-1:0]  pulse_start;
  logic [TimeW-1:0]  last_counted;
  logic [TimeW-1:0]  armed_time;
  logic              pulse_open;
  logic              batch_open;
  logic [CountW-1:0] pulse_count;
  result_t           totals_due[$];

  // Track one pin edge: guard and slot checks first, then open or close a pulse.
  function automatic void track_edge(logic [TimeW-1:0] now, logic low, logic active);
    logic [TimeW-1:0] since_arm;
    logic [TimeW-1:0] width;
    logic [TimeW-1:0] spacing;
    since_arm = now - armed_time;
    if (!active || since_arm < regs.arm_guard_ms) return;
    if (low) begin
      pulse_start = now;
      pulse_open  = 1'b1;
      return;
    end
    if (!pulse_open) return;
    pulse_open = 1'b0;
    width      = now - pulse_start;
    spacing    = now - last_counted;
    if (width < regs.pulse_min_ms || width > regs.pulse_max_ms) return;
    if (spacing < regs.debounce_ms) return;
    if (pulse_count != CountMax) pulse_count = pulse_count + 1'b1;
    last_counted = now;
  endfunction

  function automatic result_t batch_result(item_t w);
    result_t          r;
    logic [TimeW-1:0] quiet;
    r     = '0;
    quiet = w.now_ms - last_counted;
    case (w.cmd)
      CMD_EDGE: begin
        track_edge(w.now_ms, w.pin_low, w.slot_active);
      end
      CMD_POLL: begin
        if (pulse_count != 0) begin
          batch_open = 1'b1;
          if (quiet >= regs.wait_ms) begin
            r.batch_valid = 1'b1;
            r.coin_total  = pulse_count;
            pulse_count   = '0;
            batch_open    = 1'b0;
          end
        end
      end
      CMD_ARM: begin
        armed_time = w.now_ms;
      end
      default: begin
      end
    endcase
    r.collecting = batch_open;
    return r;
  endfunction

  always @(posedge clk) begin
    item_t   w;
    result_t got;
    result_t want;
    if (!rst_n) begin
      regs.pulse_min_ms = PulseMinRst;
      regs.pulse_max_ms = PulseMaxRst;
      regs.debounce_ms  = DebounceRst;
      regs.arm_guard_ms = ArmGuardRst;
      regs.wait_ms      = WaitRst;
      pulse_start  = '0;
      last_counted = '0;
      armed_time   = '0;
      pulse_open   = 1'b0;
      batch_open   = 1'b0;
      pulse_count  = '0;
      totals_due.delete();
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_PULSE_MIN: regs.pulse_min_ms = cfg_data;
          REG_PULSE_MAX: regs.pulse_max_ms = cfg_data;
          REG_DEBOUNCE:  regs.debounce_ms  = cfg_data;
          REG_ARM_GUARD: regs.arm_guard_ms = cfg_data;
          REG_WAIT:      regs.wait_ms      = cfg_data;
          default: begin
          end
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.batch_valid = out_tuser;
        got.coin_total  = out_tdata[7:0];
        got.collecting  = out_tdata[8];
        results_seen++;
        if (got.batch_valid) batches_seen++;
        if (totals_due.size() == 0) begin
          $error("unexpected result word: batch_valid %0d coin_total %0d collecting %0d",
                 got.batch_valid, got.coin_total, got.collecting);
          mismatches++;
        end else begin
          want = totals_due.pop_front();
          if (got.batch_valid !== want.batch_valid) begin
            $error("batch_valid: expected %0d, got %0d", want.batch_valid, got.batch_valid);
            mismatches++;
          end
          if (got.coin_total !== want.coin_total) begin
            $error("coin_total: expected %0d, got %0d", want.coin_total, got.coin_total);
            mismatches++;
          end
          if (got.collecting !== want.collecting) begin
            $error("collecting: expected %0d, got %0d", want.collecting, got.collecting);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        w.cmd         = cmd_t'(in_tuser);
        w.now_ms      = in_tdata[31:0];
        w.pin_low     = in_tdata[32];
        w.slot_active = in_tdata[33];
        totals_due.push_back(batch_result(w));
      end
    end
    results_due = totals_due.size();
  end

endmodule

>>> dv/coin_pulse_qualifier_batcher_unit_tb.sv
// Testbench top for the coin pulse qualifier batcher: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module coin_pulse_qualifier_batcher_unit_tb;
  import cpqb_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam int          HoldCycles = 300;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [39:0]        in_tdata   = '0;   // [31:0] now_ms, [32] pin_low, [33] slot_active
  logic [CmdW-1:0]    in_tuser   = '0;   // [1:0] cmd
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [15:0]        out_tdata;         // [7:0] coin_total, [8] collecting
  logic               out_tuser;         // [0] batch_valid
  logic               cfg_we     = 1'b0;
  logic [CfgIdxW-1:0] cfg_index  = '0;
  logic [CfgW-1:0]    cfg_data   = '0;

  int mismatches;
  int results_due;
  int results_seen;
  int batches_seen;

  // Stimulus bookkeeping: running millisecond clock and the settings now in the block.
  logic [31:0] t_ms;
  cfg_t        cur;
  bit          tx_idle   = 1'b0;
  bit          rx_idle   = 1'b0;
  bit          hold_req  = 1'b0;
  int          words_sent = 0;
  int          settings_used = 1;
  int unsigned cycle_count = 0;

  coin_pulse_qualifier_batcher_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cpqb_batch_checker batch_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .results_due  (results_due),
    .results_seen (results_seen),
    .batches_seen (batches_seen)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one word, optionally after a random gap, and hold it until accepted.
  // Starts and returns on a falling edge; valid is only lowered when a gap follows.
  task automatic send_word(cmd_t c, logic [31:0] now, logic low, logic act);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {6'd0, act, low, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Stop offering and hold until every result in flight has been taken.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
  endtask

  // Write all five registers on consecutive cycles; the block is idle here.
  task automatic write_regs(cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PULSE_MIN;
    cfg_data  <= c.pulse_min_ms;
    @(negedge clk);
    cfg_index <= REG_PULSE_MAX;
    cfg_data  <= c.pulse_max_ms;
    @(negedge clk);
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= c.debounce_ms;
    @(negedge clk);
    cfg_index <= REG_ARM_GUARD;
    cfg_data  <= c.arm_guard_ms;
    @(negedge clk);
    cfg_index <= REG_WAIT;
    cfg_data  <= c.wait_ms;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur = c;
    settings_used++;
  endtask

  // One coin insertion: arm the relay, clear the guard, drop a run of pulses,
  // then poll for the batch. A clean run keeps every pulse qualifying; otherwise
  // widths hug the bounds, spacing sometimes breaks debounce, and stray edges,
  // early polls and unused commands are mixed in.
  task automatic coin_burst(int pulses, bit clean);
    int          k;
    int          w;
    int          sp;
    logic [31:0] rise_ms;
    rise_ms = t_ms;
    send_word(CMD_ARM, t_ms, $urandom_range(0, 1), $urandom_range(0, 1));
    // falling edge inside the guard window: must be dropped
    if (!clean && cur.arm_guard_ms != 0 && $urandom_range(0, 3) == 0)
      send_word(CMD_EDGE, t_ms + $urandom_range(0, cur.arm_guard_ms - 1), 1'b1, 1'b1);
    t_ms += cur.arm_guard_ms + $urandom_range(0, 40);
    for (k = 0; k < pulses; k++) begin
      if (!clean) begin
        case ($urandom_range(0, 11))
          0: send_word(CMD_EDGE, t_ms, 1'b1, 1'b1);            // restarted by next fall
          1: send_word(CMD_EDGE, t_ms, $urandom_range(0, 1), 1'b0);  // slot closed
          2: send_word(CMD_EDGE, t_ms, 1'b0, 1'b1);            // rise with no pulse open
          3: send_word(CMD_POLL, t_ms, $urandom_range(0, 1), $urandom_range(0, 1));
          4: send_word(CMD_NONE, t_ms, $urandom_range(0, 1), $urandom_range(0, 1));
          default: begin
          end
        endcase
        t_ms += $urandom_range(0, 15);
      end
      if (clean) begin
        w = $urandom_range(cur.pulse_min_ms, cur.pulse_max_ms);
      end else begin
        case ($urandom_range(0, 9))
          0: w = (cur.pulse_min_ms == 0) ? 0 : cur.pulse_min_ms - 1;
          1: w = cur.pulse_max_ms + 1;
          2: w = cur.pulse_min_ms;
          3: w = cur.pulse_max_ms;
          default: w = $urandom_range(cur.pulse_min_ms, cur.pulse_max_ms);
        endcase
      end
      send_word(CMD_EDGE, t_ms, 1'b1, 1'b1);
      t_ms += w;
      send_word(CMD_EDGE, t_ms, 1'b0, 1'b1);
      rise_ms = t_ms;
      if (!clean && $urandom_range(0, 4) == 0) sp = $urandom_range(0, cur.debounce_ms);
      else sp = cur.debounce_ms + $urandom_range(0, 60);
      t_ms += sp;
    end
    // poll one tick short of the quiet time after the last rise
    if (!clean && cur.wait_ms != 0 && $urandom_range(0, 1) == 0)
      send_word(CMD_POLL, rise_ms + cur.wait_ms - 1, $urandom_range(0, 1),
                $urandom_range(0, 1));
    t_ms = rise_ms + cur.wait_ms + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 200));
    send_word(CMD_POLL, t_ms, $urandom_range(0, 1), $urandom_range(0, 1));
    t_ms += $urandom_range(1, 100);
  endtask

  // Unstructured words: any command, any timestamp, any levels.
  task automatic noise_words(int n);
    int k;
    for (k = 0; k < n; k++) begin
      if (k % 20 == 0) begin
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
      end
      send_word(cmd_t'($urandom_range(0, 3)), $urandom, $urandom_range(0, 1),
                $urandom_range(0, 1));
    end
  endtask

  // Receiver: random stall before each word, plus one long hold-off on request
  // so the output and input registers both fill and in_tready drops.
  initial begin
    int stall;
    int held;
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        for (held = 0; held < HoldCycles; held++) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = rx_idle ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    cfg_t c;
    int   ph;
    int   phase_end;

    cur.pulse_min_ms = PulseMinRst;
    cur.pulse_max_ms = PulseMaxRst;
    cur.debounce_ms  = DebounceRst;
    cur.arm_guard_ms = ArmGuardRst;
    cur.wait_ms      = WaitRst;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words at reset settings (min 20, max 150, debounce 30, guard 100,
    // wait 500). The guard from armed time zero covers the first 100 ms.
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_word(CMD_EDGE, 32'd50,   1'b1, 1'b1);   // inside reset guard: dropped
    send_word(CMD_NONE, 32'd60,   1'b1, 1'b1);   // unused command
    send_word(CMD_POLL, 32'd70,   1'b0, 1'b0);   // poll with empty count
    send_word(CMD_EDGE, 32'd200,  1'b0, 1'b1);   // rise with no pulse open
    send_word(CMD_EDGE, 32'd300,  1'b1, 1'b0);   // slot inactive
    send_word(CMD_EDGE, 32'd300,  1'b1, 1'b1);
    send_word(CMD_EDGE, 32'd310,  1'b1, 1'b1);   // repeated fall restarts pulse
    send_word(CMD_EDGE, 32'd340,  1'b0, 1'b1);   // width 30: count 1
    send_word(CMD_EDGE, 32'd400,  1'b1, 1'b1);
    send_word(CMD_EDGE, 32'd410,  1'b0, 1'b1);   // too short, still closes
    send_word(CMD_EDGE, 32'd500,  1'b1, 1'b1);
    send_word(CMD_EDGE, 32'd651,  1'b0, 1'b1);   // one over max
    send_word(CMD_EDGE, 32'd700,  1'b1, 1'b1);
    send_word(CMD_EDGE, 32'd720,  1'b0, 1'b1);   // exactly min: count 2
    send_word(CMD_EDGE, 32'd725,  1'b1, 1'b1);
    send_word(CMD_EDGE, 32'd745,  1'b0, 1'b1);   // debounce violation
    send_word(CMD_EDGE, 32'd800,  1'b1, 1'b1);
    send_word(CMD_EDGE, 32'd950,  1'b0, 1'b1);   // exactly max: count 3
    send_word(CMD_POLL, 32'd1000, 1'b1, 1'b1);   // before quiet time: collecting
    send_word(CMD_ARM,  32'd1100, 1'b0, 1'b0);
    send_word(CMD_EDGE, 32'd1150, 1'b1, 1'b1);   // inside arm guard
    send_word(CMD_POLL, 32'd1450, 1'b0, 1'b1);   // exactly quiet time: report 3
    send_word(CMD_ARM,  32'hFFFF_FFF0, 1'b1, 1'b0);
    send_word(CMD_EDGE, 32'h0000_0060, 1'b1, 1'b1);  // guard spans the wrap
    send_word(CMD_EDGE, 32'h0000_0080, 1'b0, 1'b1);
    send_word(CMD_POLL, 32'hFFFF_FFFF, 1'b1, 1'b1);  // all-ones timestamp
    t_ms = 32'h0000_1000;

    // Phases of different settings; each begins once the block is idle.
    for (ph = 0; ph < 10; ph++) begin
      drain_results();
      case (ph)
        0: begin
          c.pulse_min_ms = PulseMinRst;
          c.pulse_max_ms = PulseMaxRst;
          c.debounce_ms  = DebounceRst;
          c.arm_guard_ms = ArmGuardRst;
          c.wait_ms      = WaitRst;
        end
        1: c = '0;
        2: c = '1;
        3: begin
          // inverted bounds: nothing may qualify
          c.pulse_min_ms = 16'd200;
          c.pulse_max_ms = 16'd50;
          c.debounce_ms  = 16'd30;
          c.arm_guard_ms = 16'd50;
          c.wait_ms      = 16'd300;
        end
        4: begin
          c.pulse_min_ms = 16'd3;
          c.pulse_max_ms = 16'd8;
          c.debounce_ms  = 16'd1;
          c.arm_guard_ms = 16'd0;
          c.wait_ms      = 16'd1;
        end
        default: begin
          c.pulse_min_ms = $urandom_range(0, 60);
          c.pulse_max_ms = c.pulse_min_ms + $urandom_range(0, 200);
          c.debounce_ms  = $urandom_range(0, 150);
          c.arm_guard_ms = $urandom_range(0, 300);
          c.wait_ms      = $urandom_range(0, 1500);
        end
      endcase
      write_regs(c);

      // run one phase across the 32-bit wrap
      if (ph == 6) t_ms = 32'hFFFF_F000 + $urandom_range(0, 2048);

      if (ph == 9) begin
        noise_words(150);
      end else begin
        if (ph == 0) begin
          // long receiver hold-off with the sender pushing back to back
          tx_idle  = 1'b0;
          hold_req = 1'b1;
          coin_burst(6, 1'b0);
        end
        if (ph == 1) begin
          // zero settings let every fall/rise pair qualify: run the count into saturation at 255
          tx_idle = $urandom_range(0, 1);
          rx_idle = $urandom_range(0, 1);
          coin_burst(270, 1'b1);
        end
        phase_end = words_sent + 85;
        while (words_sent < phase_end) begin
          tx_idle = $urandom_range(0, 3) != 0;
          rx_idle = $urandom_range(0, 2) != 0;
          coin_burst($urandom_range(1, 6), 1'b0);
        end
      end
    end

    drain_results();
    repeat (4) @(negedge clk);

    $display("Covered %0d input words under %0d register settings (defaults, zeros, all ones,",
             words_sent, settings_used);
    $display("  inverted bounds, timestamp wrap); %0d results checked, %0d batches reported.",
             results_seen, batches_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
